// ----- rtl/pswa_pkg.sv -----
// Package for the per-id sliding window average unit.
// Holds field widths, stream packing widths, opcodes and parameter defaults.
// No dependencies.
package pswa_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned CHANNEL_W  = 6;
  localparam int unsigned INTERVAL_W = 40;
  localparam int unsigned AVERAGE_W  = 40;
  localparam int unsigned COUNT_W    = 32;

  // s_axis tdata: opcode, channel, process_interval, thread_interval
  localparam int unsigned IN_DATA_W  = 88;
  // m_axis tdata: process_average, thread_average, call_count
  localparam int unsigned OUT_DATA_W = 112;

  localparam int unsigned WINDOW_DEF    = 32;
  localparam int unsigned CHANNELS_DEF  = 64;
  localparam int unsigned TIME_BITS_DEF = 40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

endpackage

// ----- rtl/per_id_sliding_window_average_unit.sv -----
// Per-id sliding window average unit: top level.
// Depends on pswa_pkg and pswa_meta_next.
// Pipeline: the state read and history read registers, then the result register.
// Throughput: one item per cycle while the output is not stalled, set by the
// single read and write port of the channel-state and history memories.
// Reset: a clearing pass zeroes the channel-state memory entry by entry,
// with s_axis_tready_o low; history memory is not cleared.
module per_id_sliding_window_average_unit #(
  parameter int unsigned WINDOW    = pswa_pkg::WINDOW_DEF,
  parameter int unsigned CHANNELS  = pswa_pkg::CHANNELS_DEF,
  parameter int unsigned TIME_BITS = pswa_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // opcode, channel, process_interval, thread_interval
  input  logic [pswa_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // process_average, thread_average, call_count
  output logic [pswa_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned HA_W   = $clog2(CHANNELS * WINDOW);
  localparam int unsigned CHX_W  = CH_W + pswa_pkg::CHANNEL_W;
  localparam int unsigned OP_W   = pswa_pkg::OPCODE_W;
  localparam int unsigned CN_W   = pswa_pkg::CHANNEL_W;
  localparam int unsigned IV_W   = pswa_pkg::INTERVAL_W;
  localparam int unsigned AV_W   = pswa_pkg::AVERAGE_W;
  localparam int unsigned CT_W   = pswa_pkg::COUNT_W;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [FILL_W-1:0]    fill;
    logic [TIME_BITS-1:0] psum;
    logic [TIME_BITS-1:0] tsum;
    logic [CT_W-1:0]      cnt;
  } meta_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] tq;
    logic [TIME_BITS-1:0] pq;
  } hist_t;

  meta_t meta_mem [CHANNELS];
  hist_t hist_mem [CHANNELS * WINDOW];

  logic adv;
  logic accept;

  // reset clearing pass
  logic            clr_busy_q;
  logic [CH_W-1:0] clr_cnt_q;

  // input unpack
  logic [OP_W-1:0]  in_op;
  logic [CN_W-1:0]  in_ch;
  logic [IV_W-1:0]  in_p;
  logic [IV_W-1:0]  in_t;
  logic [CHX_W-1:0] in_chx;
  logic [CH_W-1:0]  in_idx;

  // stage 1
  logic                 s1_vq;
  logic [OP_W-1:0]      s1_op_q;
  logic [CN_W-1:0]      s1_ch_q;
  logic [TIME_BITS-1:0] s1_p_q;
  logic [TIME_BITS-1:0] s1_t_q;
  meta_t                meta_rd_q;
  logic [CHX_W-1:0]     s1_chx;
  logic [CH_W-1:0]      s1_idx;
  logic                 s1_inr;
  meta_t                s1_meta;
  logic [HA_W-1:0]      s1_haddr;

  // stage 2
  logic                 s2_vq;
  logic [OP_W-1:0]      s2_op_q;
  logic [CN_W-1:0]      s2_ch_q;
  logic [CH_W-1:0]      s2_idx_q;
  logic                 s2_inr_q;
  meta_t                s2_meta_q;
  logic [TIME_BITS-1:0] s2_pq_q;
  logic [TIME_BITS-1:0] s2_tq_q;
  logic [HA_W-1:0]      s2_haddr_q;
  hist_t                hist_rd_q;
  meta_t                s2_next;
  logic                 s2_hist_we;
  logic                 s2_write;

  // last state write, for the read that missed it
  logic        lw_vq;
  logic [CN_W-1:0] lw_ch_q;
  meta_t       lw_meta_q;

  // result register
  logic            out_vq;
  logic [AV_W-1:0] out_p_q;
  logic [AV_W-1:0] out_t_q;
  logic [CT_W-1:0] out_cnt_q;

  assign adv             = !out_vq || m_axis_tready_i;
  assign s_axis_tready_o = adv && !clr_busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = {out_cnt_q, out_t_q, out_p_q};

  assign in_op  = s_axis_tdata_i[OP_W-1:0];
  assign in_ch  = s_axis_tdata_i[OP_W +: CN_W];
  assign in_p   = s_axis_tdata_i[OP_W + CN_W +: IV_W];
  assign in_t   = s_axis_tdata_i[OP_W + CN_W + IV_W +: IV_W];
  assign in_chx = CHX_W'(in_ch);
  assign in_idx = in_chx[CH_W-1:0];

  // stage 1: forward the newest state of the channel
  assign s1_chx = CHX_W'(s1_ch_q);
  assign s1_idx = s1_chx[CH_W-1:0];
  assign s1_inr = (32'(s1_ch_q) < 32'(CHANNELS));

  always_comb begin
    priority if (s2_vq && s2_inr_q && (s2_ch_q == s1_ch_q)) begin
      s1_meta = s2_next;
    end else if (lw_vq && (lw_ch_q == s1_ch_q)) begin
      s1_meta = lw_meta_q;
    end else begin
      s1_meta = meta_rd_q;
    end
  end

  assign s1_haddr = HA_W'(s1_idx) * HA_W'(WINDOW) + HA_W'(s1_meta.slot);

  // stage 2
  pswa_meta_next #(
    .WINDOW    (WINDOW),
    .TIME_BITS (TIME_BITS)
  ) u_meta_next (
    .op_i      (s2_op_q),
    .slot_i    (s2_meta_q.slot),
    .fill_i    (s2_meta_q.fill),
    .psum_i    (s2_meta_q.psum),
    .tsum_i    (s2_meta_q.tsum),
    .cnt_i     (s2_meta_q.cnt),
    .pnew_q_i  (s2_pq_q),
    .tnew_q_i  (s2_tq_q),
    .pold_q_i  (hist_rd_q.pq),
    .told_q_i  (hist_rd_q.tq),
    .slot_o    (s2_next.slot),
    .fill_o    (s2_next.fill),
    .psum_o    (s2_next.psum),
    .tsum_o    (s2_next.tsum),
    .cnt_o     (s2_next.cnt),
    .hist_we_o (s2_hist_we)
  );

  assign s2_write = adv && s2_vq && s2_inr_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_vq      <= 1'b0;
      s2_vq      <= 1'b0;
      out_vq     <= 1'b0;
      lw_vq      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + CH_W'(1);
        if (clr_cnt_q == CH_W'(CHANNELS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_vq  <= accept;
        s2_vq  <= s1_vq;
        out_vq <= s2_vq;
        lw_vq  <= s2_vq && s2_inr_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= in_op;
      s1_ch_q    <= in_ch;
      s1_p_q     <= TIME_BITS'(in_p);
      s1_t_q     <= TIME_BITS'(in_t);
      s2_op_q    <= s1_op_q;
      s2_ch_q    <= s1_ch_q;
      s2_idx_q   <= s1_idx;
      s2_inr_q   <= s1_inr;
      s2_meta_q  <= s1_meta;
      s2_pq_q    <= TIME_BITS'(s1_p_q / WINDOW);
      s2_tq_q    <= TIME_BITS'(s1_t_q / WINDOW);
      s2_haddr_q <= s1_haddr;
      lw_ch_q    <= s2_ch_q;
      lw_meta_q  <= s2_next;
      if (s2_inr_q) begin
        out_p_q   <= AV_W'(s2_next.psum);
        out_t_q   <= AV_W'(s2_next.tsum);
        out_cnt_q <= s2_next.cnt;
      end else begin
        out_p_q   <= '0;
        out_t_q   <= '0;
        out_cnt_q <= '0;
      end
    end
  end

  // channel-state memory
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      meta_mem[clr_cnt_q] <= '0;
    end else if (s2_write) begin
      meta_mem[s2_idx_q] <= s2_next;
    end
    if (adv) begin
      meta_rd_q <= meta_mem[in_idx];
    end
  end

  // history memory, holds interval / WINDOW
  always_ff @(posedge clk_i) begin
    if (s2_write && s2_hist_we) begin
      hist_mem[s2_haddr_q] <= '{tq: s2_tq_q, pq: s2_pq_q};
    end
    if (adv) begin
      hist_rd_q <= hist_mem[s1_haddr];
    end
  end

endmodule

// ----- rtl/pswa_meta_next.sv -----
// Next channel state for one item: window slide, clear or read.
// Depends on pswa_pkg (opcodes).
module pswa_meta_next #(
  parameter int unsigned WINDOW    = pswa_pkg::WINDOW_DEF,
  parameter int unsigned TIME_BITS = pswa_pkg::TIME_BITS_DEF,
  localparam int unsigned SLOT_W   = $clog2(WINDOW),
  localparam int unsigned FILL_W   = $clog2(WINDOW + 1)
) (
  input  logic [pswa_pkg::OPCODE_W-1:0] op_i,
  input  logic [SLOT_W-1:0]             slot_i,
  input  logic [FILL_W-1:0]             fill_i,
  input  logic [TIME_BITS-1:0]          psum_i,
  input  logic [TIME_BITS-1:0]          tsum_i,
  input  logic [pswa_pkg::COUNT_W-1:0]  cnt_i,
  input  logic [TIME_BITS-1:0]          pnew_q_i,  // new process interval / WINDOW
  input  logic [TIME_BITS-1:0]          tnew_q_i,  // new thread interval / WINDOW
  input  logic [TIME_BITS-1:0]          pold_q_i,  // oldest process entry / WINDOW
  input  logic [TIME_BITS-1:0]          told_q_i,  // oldest thread entry / WINDOW
  output logic [SLOT_W-1:0]             slot_o,
  output logic [FILL_W-1:0]             fill_o,
  output logic [TIME_BITS-1:0]          psum_o,
  output logic [TIME_BITS-1:0]          tsum_o,
  output logic [pswa_pkg::COUNT_W-1:0]  cnt_o,
  output logic                          hist_we_o
);

  logic                 full;
  logic [TIME_BITS-1:0] pold;
  logic [TIME_BITS-1:0] told;

  assign full = (fill_i == FILL_W'(WINDOW));
  assign pold = full ? pold_q_i : '0;
  assign told = full ? told_q_i : '0;

  always_comb begin
    slot_o    = slot_i;
    fill_o    = fill_i;
    psum_o    = psum_i;
    tsum_o    = tsum_i;
    cnt_o     = cnt_i;
    hist_we_o = 1'b0;
    unique case (op_i)
      pswa_pkg::OP_UPDATE: begin
        slot_o    = (slot_i == SLOT_W'(WINDOW - 1)) ? '0 : slot_i + SLOT_W'(1);
        fill_o    = full ? fill_i : fill_i + FILL_W'(1);
        psum_o    = psum_i - pold + pnew_q_i;
        tsum_o    = tsum_i - told + tnew_q_i;
        cnt_o     = cnt_i + pswa_pkg::COUNT_W'(1);
        hist_we_o = 1'b1;
      end
      pswa_pkg::OP_CLEAR: begin
        slot_o = '0;
        fill_o = '0;
        psum_o = '0;
        tsum_o = '0;
        cnt_o  = '0;
      end
      default: begin
        // read, and the unused code, leave the channel as it is
      end
    endcase
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for per_id_sliding_window_average_unit: directed, random, stall and back-to-back tests
// against a per-channel window-average predictor. Depends on pswa_pkg and the unit RTL.
module tb;

  localparam int unsigned NCH       = pswa_pkg::CHANNELS_DEF;
  localparam int unsigned WIN       = pswa_pkg::WINDOW_DEF;
  localparam int unsigned WDOG_MAX  = 2000;
  localparam logic [pswa_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;
  localparam logic [pswa_pkg::INTERVAL_W-1:0] IVL_MAX = {pswa_pkg::INTERVAL_W{1'b1}};

  typedef struct packed {
    logic [pswa_pkg::COUNT_W-1:0]   calls;
    logic [pswa_pkg::AVERAGE_W-1:0] thr_avg;
    logic [pswa_pkg::AVERAGE_W-1:0] proc_avg;
  } avg_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_valid = 1'b0;
  logic                            s_ready;
  logic [pswa_pkg::IN_DATA_W-1:0]  s_data = '0;
  logic                            m_valid;
  logic                            m_ready = 1'b0;
  logic [pswa_pkg::OUT_DATA_W-1:0] m_data;

  per_id_sliding_window_average_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5 clk_i = ~clk_i;

  // per-channel window state
  logic [pswa_pkg::INTERVAL_W-1:0] proc_hist [NCH][WIN];
  logic [pswa_pkg::INTERVAL_W-1:0] thr_hist  [NCH][WIN];
  logic [4:0]                      oldest_slot [NCH];
  int unsigned                     fill_cnt [NCH];
  logic [pswa_pkg::AVERAGE_W-1:0]  proc_avg_st [NCH];
  logic [pswa_pkg::AVERAGE_W-1:0]  thr_avg_st  [NCH];
  logic [pswa_pkg::COUNT_W-1:0]    calls_st    [NCH];

  avg_result_t expected_avgs [$];
  int unsigned mismatches = 0;
  bit          idle_en = 1'b1;
  int unsigned rx_hold_cycles = 0;
  int unsigned quiet_cycles = 0;
  logic [pswa_pkg::CHANNEL_W-1:0] hot_ch [4];

  function automatic avg_result_t predict_window_average(
      input logic [pswa_pkg::OPCODE_W-1:0] op,
      input logic [pswa_pkg::CHANNEL_W-1:0] ch,
      input logic [pswa_pkg::INTERVAL_W-1:0] p_new,
      input logic [pswa_pkg::INTERVAL_W-1:0] t_new);
    avg_result_t r;
    logic [pswa_pkg::INTERVAL_W-1:0] p_old;
    logic [pswa_pkg::INTERVAL_W-1:0] t_old;
    p_old = '0;
    t_old = '0;
    if (op == pswa_pkg::OP_UPDATE) begin
      if (fill_cnt[ch] >= WIN) begin
        p_old = proc_hist[ch][oldest_slot[ch]];
        t_old = thr_hist[ch][oldest_slot[ch]];
      end else begin
        fill_cnt[ch]++;
      end
      proc_hist[ch][oldest_slot[ch]] = p_new;
      thr_hist[ch][oldest_slot[ch]]  = t_new;
      oldest_slot[ch] = oldest_slot[ch] + 5'd1;
      proc_avg_st[ch] = proc_avg_st[ch] - p_old / WIN + p_new / WIN;
      thr_avg_st[ch]  = thr_avg_st[ch] - t_old / WIN + t_new / WIN;
      calls_st[ch]    = calls_st[ch] + 1'b1;
    end else if (op == pswa_pkg::OP_CLEAR) begin
      oldest_slot[ch] = '0;
      fill_cnt[ch]    = 0;
      proc_avg_st[ch] = '0;
      thr_avg_st[ch]  = '0;
      calls_st[ch]    = '0;
    end
    r.proc_avg = proc_avg_st[ch];
    r.thr_avg  = thr_avg_st[ch];
    r.calls    = calls_st[ch];
    return r;
  endfunction

  function automatic logic [pswa_pkg::INTERVAL_W-1:0] rand_interval();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return IVL_MAX;
      1: return pswa_pkg::INTERVAL_W'($urandom_range(0, 63));
      2: return pswa_pkg::INTERVAL_W'(1) << $urandom_range(0, pswa_pkg::INTERVAL_W - 1);
      default: return r[pswa_pkg::INTERVAL_W-1:0];
    endcase
  endfunction

  task automatic send_item(input logic [pswa_pkg::OPCODE_W-1:0] op,
      input logic [pswa_pkg::CHANNEL_W-1:0] ch,
      input logic [pswa_pkg::INTERVAL_W-1:0] p_ivl,
      input logic [pswa_pkg::INTERVAL_W-1:0] t_ivl);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {t_ivl, p_ivl, ch, op};
    do @(posedge clk_i); while (!s_ready);
    expected_avgs.insert(expected_avgs.size(), predict_window_average(op, ch, p_ivl, t_ivl));
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    s_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random_item(input int unsigned clear_odds);
    logic [pswa_pkg::CHANNEL_W-1:0] ch;
    logic [pswa_pkg::OPCODE_W-1:0]  op;
    int unsigned pick;
    ch = ($urandom_range(0, 9) == 0) ? pswa_pkg::CHANNEL_W'($urandom_range(0, NCH - 1))
                                     : hot_ch[$urandom_range(0, 3)];
    pick = $urandom_range(0, 99);
    if (pick < clear_odds)      op = pswa_pkg::OP_CLEAR;
    else if (pick < 80)         op = pswa_pkg::OP_UPDATE;
    else if (pick < 95)         op = pswa_pkg::OP_READ;
    else                        op = OP_SPARE;
    send_item(op, ch, rand_interval(), rand_interval());
  endtask

  task automatic test_directed();
    send_item(pswa_pkg::OP_READ, 6'd0, '0, '0);
    send_item(OP_SPARE, 6'd63, IVL_MAX, IVL_MAX);
    send_item(pswa_pkg::OP_UPDATE, 6'd0, IVL_MAX, IVL_MAX);
    send_item(pswa_pkg::OP_UPDATE, 6'd0, 40'd31, 40'd31);
    send_item(pswa_pkg::OP_UPDATE, 6'd0, 40'd32, 40'd0);
    send_item(pswa_pkg::OP_READ, 6'd0, '0, '0);
    send_item(pswa_pkg::OP_UPDATE, 6'd63, IVL_MAX, '0);
    send_item(pswa_pkg::OP_UPDATE, 6'd63, '0, IVL_MAX);
    send_item(pswa_pkg::OP_CLEAR, 6'd63, IVL_MAX, IVL_MAX);
    send_item(pswa_pkg::OP_READ, 6'd63, '0, '0);
    send_item(pswa_pkg::OP_CLEAR, 6'd5, '0, '0);
    send_item(pswa_pkg::OP_UPDATE, 6'd5, 40'hAA_AAAA_AAAA, 40'h55_5555_5555);
    send_item(pswa_pkg::OP_UPDATE, 6'd5, 40'h55_5555_5555, 40'hAA_AAAA_AAAA);
    send_item(OP_SPARE, 6'd5, '0, '0);
    send_item(pswa_pkg::OP_UPDATE, 6'd0, 40'd1000, 40'd2000);
    send_item(pswa_pkg::OP_CLEAR, 6'd0, '0, '0);
    send_item(pswa_pkg::OP_UPDATE, 6'd0, 40'd4096, 40'd8192);
    send_item(pswa_pkg::OP_UPDATE, 6'd0, IVL_MAX, 40'd64);
    send_item(pswa_pkg::OP_READ, 6'd0, '0, '0);
    stop_sending();
  endtask

  // mostly update runs on a few channels so windows fill and wrap
  task automatic test_random_traffic();
    for (int i = 0; i < 4; i++) hot_ch[i] = pswa_pkg::CHANNEL_W'($urandom_range(0, NCH - 1));
    for (int n = 0; n < 1400; n++) begin
      if (n % 350 == 0)
        hot_ch[$urandom_range(0, 3)] = pswa_pkg::CHANNEL_W'($urandom_range(0, NCH - 1));
      send_random_item((n % 500 < 10) ? 20 : 1);
    end
    stop_sending();
  endtask

  task automatic test_output_stall();
    rx_hold_cycles = 80;
    for (int n = 0; n < 60; n++) send_random_item(1);
    stop_sending();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    for (int n = 0; n < 500; n++) begin
      if (n % 100 < 40)
        send_item(pswa_pkg::OP_UPDATE, hot_ch[0], rand_interval(), rand_interval());
      else
        send_random_item(2);
    end
    stop_sending();
  endtask

  // receiver: random hold-off bursts, plus a long hold when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
        m_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string fld, input logic [63:0] want,
      input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h actual %0h", fld, want, got);
  endtask

  always @(posedge clk_i) begin
    avg_result_t want;
    avg_result_t got;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data;
      if (expected_avgs.size() == 0) begin
        note_mismatch("unexpected item", '0, got.calls);
      end else begin
        want = expected_avgs.pop_front();
        if (got.proc_avg !== want.proc_avg)
          note_mismatch("process_average", want.proc_avg, got.proc_avg);
        if (got.thr_avg !== want.thr_avg)
          note_mismatch("thread_average", want.thr_avg, got.thr_avg);
        if (got.calls !== want.calls)
          note_mismatch("call_count", want.calls, got.calls);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < NCH; c++) begin
      oldest_slot[c] = '0;
      fill_cnt[c]    = 0;
      proc_avg_st[c] = '0;
      thr_avg_st[c]  = '0;
      calls_st[c]    = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic();
    test_output_stall();
    test_back_to_back();
    while (expected_avgs.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_avgs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
